// ===== rtl/core/lpd_pkg.sv =====
`default_nettype none

package lpd_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int FRACTION_BITS = 8;
  localparam int SENSORS       = 5;
  localparam int THRESH_W      = 10;
  localparam int GAIN_W        = 16;
  localparam int DUTY_BITS     = 7;
  localparam int ILIM_BITS     = 6;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int LOST_MAG      = 30;

  localparam int SUM_W   = SAMPLE_BITS + 3;
  localparam int WSUM_W  = SAMPLE_BITS + 3;
  localparam int WMAG_W  = SAMPLE_BITS + 2;
  localparam int NUM_W   = WMAG_W + 4 + FRACTION_BITS;
  localparam int QUO_W   = FRACTION_BITS + 5;
  localparam int ERR_W   = QUO_W + 1;
  localparam int INT_W   = ILIM_BITS + FRACTION_BITS + 1;
  localparam int ISUM_W  = INT_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int OPND_W  = FRACTION_BITS + 9;
  localparam int ACC_W   = OPND_W;
  localparam int CORR_W  = ACC_W + GAIN_W;
  localparam int DUTY_W  = CORR_W + 1;
  localparam int CMP_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam int ITER_MAX = (GAIN_W > QUO_W) ? GAIN_W : QUO_W;
  localparam int CNT_W   = $clog2(ITER_MAX);
  localparam int LOST_ERR = LOST_MAG * (1 << FRACTION_BITS);

  localparam logic [GAIN_W-1:0]    KP_RESET     = GAIN_W'(8960);
  localparam logic [GAIN_W-1:0]    KI_RESET     = GAIN_W'(3);
  localparam logic [GAIN_W-1:0]    KD_RESET     = GAIN_W'(15360);
  localparam logic [THRESH_W-1:0]  THRESH_RESET = THRESH_W'(500);
  localparam logic [DUTY_BITS-1:0] BASE_RESET   = DUTY_BITS'(80);
  localparam logic [DUTY_BITS-1:0] MIN_RESET    = DUTY_BITS'(50);
  localparam logic [DUTY_BITS-1:0] MAX_RESET    = DUTY_BITS'(85);
  localparam logic [ILIM_BITS-1:0] ILIM_RESET   = ILIM_BITS'(30);

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic [DUTY_BITS-1:0]    duty_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP,
    CFG_KI,
    CFG_KD,
    CFG_THRESH,
    CFG_BASE,
    CFG_MIN,
    CFG_MAX,
    CFG_ILIM
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_MUL,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/lpd_intf.sv =====
`default_nettype none

interface lpd_sample_if;
  import lpd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_far_left;
  sample_t sample_near_left;
  sample_t sample_center;
  sample_t sample_near_right;
  sample_t sample_far_right;
  modport source (output valid, sample_far_left, sample_near_left, sample_center,
                  sample_near_right, sample_far_right, input ready);
  modport sink (input valid, sample_far_left, sample_near_left, sample_center,
                sample_near_right, sample_far_right, output ready);
endinterface

interface lpd_cfg_if;
  import lpd_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_reg_e              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface lpd_result_if;
  import lpd_pkg::*;
  logic  valid;
  logic  ready;
  duty_t left_motor_duty;
  duty_t right_motor_duty;
  err_t  scaled_line_error;
  logic  line_lost;
  modport source (output valid, left_motor_duty, right_motor_duty, scaled_line_error,
                  line_lost, input ready);
  modport sink (input valid, left_motor_duty, right_motor_duty, scaled_line_error,
                line_lost, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/line_position_pid_drive_unit.sv =====
// Channel    Dir  Transfer
// sample_i   in   five line-sensor samples
// cfg_i      in   register index and write data, always ready
// result_o   out  left/right motor duty, scaled line error, line-lost flag
//
// An item is accepted in idle, then runs the restoring divider (one quotient bit a
// cycle), a setup state, the serial PID multiply (one gain bit a cycle) and a finish
// state. Line-lost items skip the divider. The finish state loads the result into the
// output register, which drives result valid.
// Reset loads the register defaults and clears last error and integral.
// A stalled result sits in the output register; the next item runs meanwhile and
// waits in its finish cycle until the output register is free.
`default_nettype none

module line_position_pid_drive_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  lpd_sample_if.sink   sample_i,
  lpd_cfg_if.sink      cfg_i,
  lpd_result_if.source result_o
);
  import lpd_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;

  logic [GAIN_W-1:0]    kp_q, ki_q, kd_q;
  logic [THRESH_W-1:0]  thresh_q;
  logic [DUTY_BITS-1:0] base_q, min_q, max_q;
  logic [ILIM_BITS-1:0] ilim_q;

  logic                     lost_q, neg_q;
  logic [SUM_W-1:0]         den_q, rem_q;
  logic [QUO_W-1:0]         quo_q;
  logic signed [ERR_W-1:0]  last_err_q;
  logic signed [INT_W-1:0]  integ_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [GAIN_W-1:0]        kp_sr_q, ki_sr_q, kd_sr_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [GAIN_W-1:0]        lo_q;

  logic                 out_valid_q;
  duty_t                out_left_q, out_right_q;
  err_t                 out_err_q;
  logic                 out_lost_q;

  // input decode
  sample_t                  smp [SENSORS];
  logic                     seen;
  logic [SUM_W-1:0]         sum;
  logic signed [SAMPLE_BITS:0] far_diff, near_diff;
  logic signed [WSUM_W-1:0] wsum;
  logic [WMAG_W-1:0]        wmag;
  logic [NUM_W-1:0]         num;

  assign smp[0] = sample_i.sample_far_left;
  assign smp[1] = sample_i.sample_near_left;
  assign smp[2] = sample_i.sample_center;
  assign smp[3] = sample_i.sample_near_right;
  assign smp[4] = sample_i.sample_far_right;

  always_comb begin
    seen = 1'b0;
    for (int k = 0; k < SENSORS; k++) begin
      seen = seen | (CMP_W'(smp[k]) > CMP_W'(thresh_q));
    end
  end

  assign sum = SUM_W'(smp[0]) + SUM_W'(smp[1]) + SUM_W'(smp[2]) + SUM_W'(smp[3])
             + SUM_W'(smp[4]);
  assign far_diff  = $signed({1'b0, smp[0]}) - $signed({1'b0, smp[4]});
  assign near_diff = $signed({1'b0, smp[1]}) - $signed({1'b0, smp[3]});
  assign wsum = (WSUM_W'(far_diff) <<< 1) + WSUM_W'(far_diff) + WSUM_W'(near_diff);
  assign wmag = wsum[WSUM_W-1] ? WMAG_W'(-wsum) : WMAG_W'(wsum);
  // times ten (8 + 2), then to fixed point
  assign num = ((NUM_W'(wmag) << 3) + (NUM_W'(wmag) << 1)) << FRACTION_BITS;

  // divider step
  logic [SUM_W:0]   rem_sh;
  logic             q_bit;
  logic [SUM_W-1:0] rem_nx;
  assign rem_sh = {rem_q, quo_q[QUO_W-1]};
  assign q_bit  = rem_sh >= {1'b0, den_q};
  assign rem_nx = q_bit ? SUM_W'(rem_sh - {1'b0, den_q}) : rem_sh[SUM_W-1:0];

  // error, integral, derivative
  logic signed [ERR_W-1:0]  quo_s, err_w;
  logic signed [ISUM_W-1:0] isum, lim_pos, lim_neg;
  logic signed [INT_W-1:0]  integ_w;
  logic signed [DIFF_W-1:0] diff_w;

  assign quo_s = $signed({1'b0, quo_q});
  always_comb begin
    if (lost_q) begin
      err_w = (last_err_q > 0) ? ERR_W'(LOST_ERR) : ERR_W'(-LOST_ERR);
    end else begin
      err_w = neg_q ? -quo_s : quo_s;
    end
  end

  assign isum    = ISUM_W'(integ_q) + ISUM_W'(err_w);
  assign lim_pos = $signed(ISUM_W'({ilim_q, {FRACTION_BITS{1'b0}}}));
  assign lim_neg = -lim_pos;
  always_comb begin
    priority if (isum > lim_pos) begin
      integ_w = INT_W'(lim_pos);
    end else if (isum < lim_neg) begin
      integ_w = INT_W'(lim_neg);
    end else begin
      integ_w = INT_W'(isum);
    end
  end
  assign diff_w = DIFF_W'(err_w) - DIFF_W'(last_err_q);

  // serial multiply-accumulate over gain bits
  logic signed [OPND_W-1:0] term_p, term_i, term_d, addend;
  logic signed [ACC_W:0]    acc_sum;
  assign term_p  = kp_sr_q[0] ? OPND_W'(last_err_q) : OPND_W'(0);
  assign term_i  = ki_sr_q[0] ? OPND_W'(integ_q)    : OPND_W'(0);
  assign term_d  = kd_sr_q[0] ? OPND_W'(diff_q)     : OPND_W'(0);
  assign addend  = term_p + term_i + term_d;
  assign acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(addend);

  // duty clamp
  logic signed [CORR_W-1:0] corr;
  logic signed [DUTY_W-1:0] base_x, left_x, right_x, hi_x, lo_x;
  assign corr    = $signed({acc_q, lo_q});
  assign base_x  = $signed(DUTY_W'({base_q, {(2*FRACTION_BITS){1'b0}}}));
  assign hi_x    = $signed(DUTY_W'({max_q, {(2*FRACTION_BITS){1'b0}}}));
  assign lo_x    = $signed(DUTY_W'({min_q, {(2*FRACTION_BITS){1'b0}}}));
  assign left_x  = base_x - DUTY_W'(corr);
  assign right_x = base_x + DUTY_W'(corr);

  function automatic duty_t duty_of(input logic signed [DUTY_W-1:0] x,
                                    input logic signed [DUTY_W-1:0] hi,
                                    input logic signed [DUTY_W-1:0] lo);
    logic signed [DUTY_W-1:0] y;
    priority if (x > hi) begin
      y = hi;
    end else if (x < lo) begin
      y = lo;
    end else begin
      y = x;
    end
    return y[2*FRACTION_BITS +: DUTY_BITS];
  endfunction

  // control
  logic fin_load;
  assign fin_load = (state_q == ST_FIN) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) state_d = seen ? ST_DIV : ST_PREP;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(QUO_W-1)) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(GAIN_W-1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == ST_DIV || state_q == ST_MUL) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else begin
      cnt_q <= '0;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= KP_RESET;
      ki_q     <= KI_RESET;
      kd_q     <= KD_RESET;
      thresh_q <= THRESH_RESET;
      base_q   <= BASE_RESET;
      min_q    <= MIN_RESET;
      max_q    <= MAX_RESET;
      ilim_q   <= ILIM_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_KP:     kp_q     <= cfg_i.data[GAIN_W-1:0];
        CFG_KI:     ki_q     <= cfg_i.data[GAIN_W-1:0];
        CFG_KD:     kd_q     <= cfg_i.data[GAIN_W-1:0];
        CFG_THRESH: thresh_q <= cfg_i.data[THRESH_W-1:0];
        CFG_BASE:   base_q   <= cfg_i.data[DUTY_BITS-1:0];
        CFG_MIN:    min_q    <= cfg_i.data[DUTY_BITS-1:0];
        CFG_MAX:    max_q    <= cfg_i.data[DUTY_BITS-1:0];
        CFG_ILIM:   ilim_q   <= cfg_i.data[ILIM_BITS-1:0];
      endcase
    end
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
    end else if (state_q == ST_PREP) begin
      last_err_q <= err_w;
      integ_q    <= integ_w;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        lost_q <= !seen;
        neg_q  <= wsum[WSUM_W-1];
        den_q  <= sum;
        rem_q  <= SUM_W'(num[NUM_W-1:QUO_W]);
        quo_q  <= num[QUO_W-1:0];
      end
      ST_DIV: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[QUO_W-2:0], q_bit};
      end
      ST_PREP: begin
        diff_q  <= diff_w;
        kp_sr_q <= kp_q;
        ki_sr_q <= ki_q;
        kd_sr_q <= kd_q;
        acc_q   <= '0;
        lo_q    <= '0;
      end
      ST_MUL: begin
        acc_q   <= acc_sum[ACC_W:1];
        lo_q    <= {acc_sum[0], lo_q[GAIN_W-1:1]};
        kp_sr_q <= kp_sr_q >> 1;
        ki_sr_q <= ki_sr_q >> 1;
        kd_sr_q <= kd_sr_q >> 1;
      end
      default: begin
      end
    endcase
  end

  assign sample_i.ready = (state_q == ST_IDLE);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !result_o.ready) || fin_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_left_q  <= duty_of(left_x, hi_x, lo_x);
      out_right_q <= duty_of(right_x, hi_x, lo_x);
      out_err_q   <= last_err_q;
      out_lost_q  <= lost_q;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.left_motor_duty   = out_left_q;
  assign result_o.right_motor_duty  = out_right_q;
  assign result_o.scaled_line_error = out_err_q;
  assign result_o.line_lost         = out_lost_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && sample_i.valid) |=> (state_q == ST_DIV || state_q == ST_PREP))
    else $error("accepted item did not start");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result valid without finish");

  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (ISUM_W'(integ_q) <= lim_pos && ISUM_W'(integ_q) >= lim_neg))
    else $error("integral outside limit");

  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_err_q <= ERR_W'(LOST_ERR)) && (last_err_q >= ERR_W'(-LOST_ERR)))
    else $error("line error out of range");

endmodule

`default_nettype wire

// ===== verif/lpd_drive_checker.sv =====
`timescale 1ns / 100ps

module lpd_drive_checker
  import lpd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  lpd_sample_if sample_i,
  lpd_cfg_if    cfg_i,
  lpd_result_if result_i,
  output int    in_flight_o,
  output int    mismatches_o
);

  typedef struct packed {
    duty_t left;
    duty_t right;
    err_t  line_error;
    logic  lost;
  } drive_t;

  localparam longint ONE  = longint'(1) << FRACTION_BITS;
  localparam longint ONE2 = longint'(1) << (2 * FRACTION_BITS);

  longint kp, ki, kd, thresh, base, duty_lo, duty_hi, ilim;
  longint last_error, error_sum;
  drive_t expected_drive_q [$];
  drive_t got, want;
  int     errors = 0;

  assign mismatches_o = errors;

  // when the bounds are crossed, values above the upper bound take it and all others the lower bound
  function automatic duty_t duty_of(input longint exact);
    longint hi, lo;
    hi = duty_hi * ONE2;
    lo = duty_lo * ONE2;
    if (exact > hi) begin
      exact = hi;
    end else if (exact < lo) begin
      exact = lo;
    end
    return duty_t'(exact >> (2 * FRACTION_BITS));
  endfunction

  function automatic drive_t predict_drive(input sample_t s0, s1, s2, s3, s4);
    longint smp [5];
    longint wsum, sum, err, diff, lim, corr;
    bit     lost;
    drive_t r;
    smp = '{longint'(s0), longint'(s1), longint'(s2), longint'(s3), longint'(s4)};
    wsum = 3 * (smp[0] - smp[4]) + (smp[1] - smp[3]);
    sum = 0;
    lost = 1'b1;
    for (int i = 0; i < 5; i++) begin
      if (smp[i] > thresh) lost = 1'b0;
      sum += smp[i];
    end
    if (lost) begin
      err = (last_error > 0) ? LOST_MAG * ONE : -LOST_MAG * ONE;
    end else if (sum != 0) begin
      err = (wsum * 10 * ONE) / sum;
    end else begin
      err = 0;
    end
    diff = err - last_error;
    lim = ilim * ONE;
    error_sum += err;
    if (error_sum > lim) begin
      error_sum = lim;
    end else if (error_sum < -lim) begin
      error_sum = -lim;
    end
    corr = kp * err + ki * error_sum + kd * diff;
    last_error = err;
    r.left = duty_of(base * ONE2 - corr);
    r.right = duty_of(base * ONE2 + corr);
    r.line_error = err_t'(err);
    r.lost = lost;
    return r;
  endfunction

  task automatic flag(input string field, input longint want_v, input longint got_v);
    errors++;
    $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp = longint'(KP_RESET);
      ki = longint'(KI_RESET);
      kd = longint'(KD_RESET);
      thresh = longint'(THRESH_RESET);
      base = longint'(BASE_RESET);
      duty_lo = longint'(MIN_RESET);
      duty_hi = longint'(MAX_RESET);
      ilim = longint'(ILIM_RESET);
      last_error = 0;
      error_sum = 0;
      expected_drive_q.delete();
      in_flight_o <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        got.left = result_i.left_motor_duty;
        got.right = result_i.right_motor_duty;
        got.line_error = result_i.scaled_line_error;
        got.lost = result_i.line_lost;
        if (expected_drive_q.size() == 0) begin
          errors++;
          $display("%0t: transfer with nothing expected: left %0d right %0d error %0d lost %0d",
                   $time, got.left, got.right, $signed(got.line_error), got.lost);
        end else begin
          want = expected_drive_q.pop_front();
          if (got.left !== want.left)
            flag("left_motor_duty", longint'(want.left), longint'(got.left));
          if (got.right !== want.right)
            flag("right_motor_duty", longint'(want.right), longint'(got.right));
          if (got.line_error !== want.line_error)
            flag("scaled_line_error", longint'($signed(want.line_error)),
                 longint'($signed(got.line_error)));
          if (got.lost !== want.lost)
            flag("line_lost", longint'(want.lost), longint'(got.lost));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_KP:     kp = longint'(cfg_i.data);
          CFG_KI:     ki = longint'(cfg_i.data);
          CFG_KD:     kd = longint'(cfg_i.data);
          CFG_THRESH: thresh = longint'(cfg_i.data[THRESH_W-1:0]);
          CFG_BASE:   base = longint'(cfg_i.data[DUTY_BITS-1:0]);
          CFG_MIN:    duty_lo = longint'(cfg_i.data[DUTY_BITS-1:0]);
          CFG_MAX:    duty_hi = longint'(cfg_i.data[DUTY_BITS-1:0]);
          CFG_ILIM:   ilim = longint'(cfg_i.data[ILIM_BITS-1:0]);
          default: ;
        endcase
      end
      if (sample_i.valid && sample_i.ready) begin
        expected_drive_q.push_back(predict_drive(sample_i.sample_far_left,
            sample_i.sample_near_left, sample_i.sample_center,
            sample_i.sample_near_right, sample_i.sample_far_right));
      end
      in_flight_o <= expected_drive_q.size();
    end
  end

endmodule

// ===== verif/line_position_pid_drive_unit_test.sv =====
`timescale 1ns / 100ps

module line_position_pid_drive_unit_test;
  import lpd_pkg::*;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  bit      idle_on = 1'b1;
  sample_t thresh_now = THRESH_RESET;
  int      favored = 0;
  int      in_flight;
  int      mismatches;

  lpd_sample_if sample_if ();
  lpd_cfg_if    cfg_if ();
  lpd_result_if result_if ();

  line_position_pid_drive_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .cfg_i   (cfg_if),
    .result_o(result_if)
  );

  lpd_drive_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .cfg_i       (cfg_if),
    .result_i    (result_if),
    .in_flight_o (in_flight),
    .mismatches_o(mismatches)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side back-pressure in random bursts while idle_on is set
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk_i);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_reading(input sample_t s0, s1, s2, s3, s4);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      sample_if.valid <= 1'b0;
      // sometimes hold off until the unit is ready so the gap hits that phase
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (!sample_if.ready);
      end
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.sample_far_left <= s0;
    sample_if.sample_near_left <= s1;
    sample_if.sample_center <= s2;
    sample_if.sample_near_right <= s3;
    sample_if.sample_far_right <= s4;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] padded(input logic [CFG_DATA_W-1:0] value,
                                                   input int width, input bit on);
    return on ? (value | (CFG_DATA_W'($urandom) << width)) : value;
  endfunction

  task automatic configure(input int phase);
    logic [GAIN_W-1:0]    kp, ki, kd;
    logic [THRESH_W-1:0]  thr;
    logic [DUTY_BITS-1:0] base, dmin, dmax;
    logic [ILIM_BITS-1:0] ilim;
    bit                   pad;
    pad = 1'b0;
    case (phase)
      1: begin
        kp = KP_RESET; ki = KI_RESET; kd = KD_RESET; thr = THRESH_RESET;
        base = BASE_RESET; dmin = MIN_RESET; dmax = MAX_RESET; ilim = ILIM_RESET;
      end
      2: begin
        kp = '1; ki = '1; kd = '1; thr = '0;
        base = 100; dmin = 0; dmax = 100; ilim = '1;
      end
      3: begin
        kp = '0; ki = '0; kd = '0; thr = '1;
        base = 0; dmin = 0; dmax = 0; ilim = '0;
      end
      4: begin
        // crossed duty bounds
        kp = GAIN_W'($urandom) >> $urandom_range(4, 15);
        ki = GAIN_W'($urandom) >> $urandom_range(4, 15);
        kd = GAIN_W'($urandom) >> $urandom_range(4, 15);
        thr = THRESH_W'($urandom_range(300, 700));
        base = DUTY_BITS'($urandom_range(0, 100));
        dmin = DUTY_BITS'($urandom_range(60, 100));
        dmax = DUTY_BITS'($urandom_range(0, 59));
        ilim = ILIM_BITS'($urandom_range(0, 63));
      end
      5: begin
        // duty registers beyond 100
        kp = GAIN_W'($urandom) >> $urandom_range(6, 15);
        ki = GAIN_W'($urandom) >> $urandom_range(6, 15);
        kd = GAIN_W'($urandom) >> $urandom_range(6, 15);
        thr = THRESH_RESET;
        base = DUTY_BITS'($urandom_range(101, 127));
        dmin = DUTY_BITS'($urandom_range(101, 127));
        dmax = '1; ilim = 1;
      end
      default: begin
        kp = GAIN_W'($urandom) >> $urandom_range(0, 15);
        ki = GAIN_W'($urandom) >> $urandom_range(0, 15);
        kd = GAIN_W'($urandom) >> $urandom_range(0, 15);
        thr = ($urandom_range(0, 1) == 1) ? THRESH_W'($urandom_range(200, 800))
                                          : THRESH_W'($urandom);
        base = DUTY_BITS'($urandom_range(0, 100));
        dmin = DUTY_BITS'($urandom_range(0, 100));
        dmax = DUTY_BITS'($urandom_range(0, 100));
        ilim = ILIM_BITS'($urandom);
        pad = 1'b1;
      end
    endcase
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_KD, kd);
    write_reg(CFG_THRESH, padded(CFG_DATA_W'(thr), THRESH_W, pad));
    write_reg(CFG_BASE, padded(CFG_DATA_W'(base), DUTY_BITS, pad));
    write_reg(CFG_MIN, padded(CFG_DATA_W'(dmin), DUTY_BITS, pad));
    write_reg(CFG_MAX, padded(CFG_DATA_W'(dmax), DUTY_BITS, pad));
    write_reg(CFG_ILIM, padded(CFG_DATA_W'(ilim), ILIM_BITS, pad));
    cfg_if.valid <= 1'b0;
    thresh_now = thr;
  endtask

  task automatic random_reading();
    sample_t s [5];
    int      mode;
    mode = $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0) favored = $urandom_range(0, 4);
    case (mode)
      0, 1, 2, 3: begin
        // line at one or two sensors, favored side persists to wind up integral
        for (int i = 0; i < 5; i++) s[i] = sample_t'($urandom_range(0, thresh_now));
        s[favored] = (thresh_now == '1) ? '1 : sample_t'($urandom_range(thresh_now + 1, 1023));
        if (mode == 0 && favored < 4) s[favored + 1] = sample_t'($urandom_range(0, 1023));
      end
      4, 5: begin
        for (int i = 0; i < 5; i++) s[i] = sample_t'($urandom_range(0, thresh_now));
      end
      6: begin
        for (int i = 0; i < 5; i++) s[i] = '0;
        if ($urandom_range(0, 1) == 1) begin
          s[$urandom_range(0, 4)] = sample_t'($urandom_range(0, thresh_now));
        end
      end
      default: begin
        for (int i = 0; i < 5; i++) begin
          case ($urandom_range(0, 3))
            0: s[i] = '0;
            1: s[i] = '1;
            default: s[i] = sample_t'($urandom);
          endcase
        end
      end
    endcase
    send_reading(s[0], s[1], s[2], s[3], s[4]);
  endtask

  initial begin
    rst_ni = 1'b0;
    sample_if.valid = 1'b0;
    sample_if.sample_far_left = '0;
    sample_if.sample_near_left = '0;
    sample_if.sample_center = '0;
    sample_if.sample_near_right = '0;
    sample_if.sample_far_right = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_KP;
    cfg_if.data = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset configuration
    send_reading(0, 0, 0, 0, 0);
    send_reading(0, 0, 0, 0, 0);
    send_reading(1023, 0, 0, 0, 0);
    send_reading(0, 0, 0, 0, 0);
    send_reading(500, 500, 500, 500, 500);
    send_reading(0, 0, 0, 0, 1023);
    send_reading(400, 0, 0, 0, 0);
    send_reading(1023, 1023, 1023, 1023, 1023);
    send_reading(0, 1023, 0, 0, 0);
    send_reading(0, 0, 0, 1023, 0);
    send_reading(0, 0, 1023, 0, 0);
    send_reading(501, 0, 0, 0, 0);
    send_reading(0, 0, 0, 0, 501);
    send_reading(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA);
    send_reading(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155);
    send_reading(1, 0, 1000, 2, 0);
    send_reading(0, 2, 1000, 0, 1);
    send_reading(1023, 1023, 0, 0, 0);
    send_reading(1023, 1023, 0, 0, 0);
    send_reading(1023, 600, 0, 0, 0);
    send_reading(0, 0, 0, 600, 1023);

    for (int phase = 0; phase <= 9; phase++) begin
      if (phase > 0) begin
        wait_idle();
        configure(phase);
      end
      if (phase == 9) idle_on <= 1'b0;
      repeat (138) random_reading();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lpd_pkg.sv
rtl/core/lpd_intf.sv
rtl/core/line_position_pid_drive_unit.sv
verif/lpd_drive_checker.sv
verif/line_position_pid_drive_unit_test.sv
